// File: hw/rtl/msrs_pkg.sv
// Package for the motor stall recovery sequencer.
// Holds phase codes, register indexes, reset values and the shared struct types.
// No dependencies.
package msrs_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_REVERSE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRIES   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_INTERVAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_POWER = 3'd6;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_REV   = 2'd1;
   localparam logic [1:0] PHASE_PAUSE = 2'd2;
   localparam logic [1:0] PHASE_COOL  = 2'd3;

   localparam logic [15:0] RST_BASE_REVERSE   = 16'd200;
   localparam logic [15:0] RST_PAUSE          = 16'd100;
   localparam logic [15:0] RST_COOLDOWN       = 16'd300;
   localparam logic [3:0]  RST_MAX_RETRIES    = 4'd3;
   localparam logic [15:0] RST_CHECK_INTERVAL = 16'd20;
   localparam logic [7:0]  RST_DEBOUNCE       = 8'd3;
   localparam logic [6:0]  RST_REVERSE_POWER  = 7'd100;

   typedef struct packed {
      logic [15:0] base_reverse_ms;
      logic [15:0] pause_ms;
      logic [15:0] cooldown_ms;
      logic [3:0]  max_retries;
      logic [15:0] check_interval_ms;
      logic [7:0]  debounce_threshold;
      logic [6:0]  reverse_power;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] phase_start_time;
      logic [31:0] last_check_time;
      logic [3:0]  retry_count;
      logic [7:0]  debounce_count;
   } seq_state_type;

   typedef struct packed {
      logic              drive_update;
      logic signed [7:0] drive_value;
      logic [1:0]        phase_now;
      logic              gave_up;
   } result_type;

endpackage

// File: hw/rtl/motor_stall_recovery_sequencer.sv
// Top level of the motor stall recovery sequencer: handshakes, CSRs and state registers.
// Depends on msrs_pkg and msrs_step.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  now_ms, stalled, target_power
//   rsp      out        rsp_valid/rsp_stall  drive_update, drive_value, phase_now, gave_up
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One item per cycle unless rsp_stall holds a valid result. A taken item goes into the
// input register and then, through the step logic, into the result register.
// Reset restores register defaults, puts the phase in idle and zeroes times and counts.
// rsp_stall holds the result; req_stall is raised only while the input register is full
// and its result cannot move.
module motor_stall_recovery_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_now_ms,
   input  logic                                 req_stalled,
   input  logic signed [7:0]                    req_target_power,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_drive_update,
   output logic signed [7:0]                    rsp_drive_value,
   output logic [1:0]                           rsp_phase_now,
   output logic                                 rsp_gave_up,
   input  logic                                 csr_write_enable,
   input  logic [msrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [msrs_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   msrs_pkg::cfg_type       cfg_ff;
   msrs_pkg::seq_state_type state_ff;
   msrs_pkg::seq_state_type state_in;
   msrs_pkg::result_type    result_in;
   msrs_pkg::result_type    result_ff;

   logic              in_valid_ff;
   logic [31:0]       in_now_ff;
   logic              in_stalled_ff;
   logic signed [7:0] in_power_ff;
   logic              rsp_valid_ff;
   logic              step_fire;
   logic              req_take;

   assign step_fire = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_fire;
   assign req_take  = req_valid && !req_stall;

   msrs_step u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .now_ms       (in_now_ff),
      .stalled      (in_stalled_ff),
      .target_power (in_power_ff),
      .nxt          (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_reverse_ms    <= msrs_pkg::RST_BASE_REVERSE;
         cfg_ff.pause_ms           <= msrs_pkg::RST_PAUSE;
         cfg_ff.cooldown_ms        <= msrs_pkg::RST_COOLDOWN;
         cfg_ff.max_retries        <= msrs_pkg::RST_MAX_RETRIES;
         cfg_ff.check_interval_ms  <= msrs_pkg::RST_CHECK_INTERVAL;
         cfg_ff.debounce_threshold <= msrs_pkg::RST_DEBOUNCE;
         cfg_ff.reverse_power      <= msrs_pkg::RST_REVERSE_POWER;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            msrs_pkg::CSR_BASE_REVERSE:   cfg_ff.base_reverse_ms    <= csr_write_data;
            msrs_pkg::CSR_PAUSE:          cfg_ff.pause_ms           <= csr_write_data;
            msrs_pkg::CSR_COOLDOWN:       cfg_ff.cooldown_ms        <= csr_write_data;
            msrs_pkg::CSR_MAX_RETRIES:    cfg_ff.max_retries        <= csr_write_data[3:0];
            msrs_pkg::CSR_CHECK_INTERVAL: cfg_ff.check_interval_ms  <= csr_write_data;
            msrs_pkg::CSR_DEBOUNCE:       cfg_ff.debounce_threshold <= csr_write_data[7:0];
            msrs_pkg::CSR_REVERSE_POWER:  cfg_ff.reverse_power      <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step_fire) begin
            state_ff <= state_in;
         end
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff     <= req_now_ms;
         in_stalled_ff <= req_stalled;
         in_power_ff   <= req_target_power;
      end
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_update = result_ff.drive_update;
   assign rsp_drive_value  = result_ff.drive_value;
   assign rsp_phase_now    = result_ff.phase_now;
   assign rsp_gave_up      = result_ff.gave_up;

endmodule

// File: hw/rtl/msrs_step.sv
// Next-state and result logic for one tick of the stall recovery sequencer.
// Depends on msrs_pkg for the phase codes and struct types.
module msrs_step (
   input  msrs_pkg::cfg_type       cfg,
   input  msrs_pkg::seq_state_type cur,
   input  logic [31:0]             now_ms,
   input  logic                    stalled,
   input  logic signed [7:0]       target_power,
   output msrs_pkg::seq_state_type nxt,
   output msrs_pkg::result_type    result
);

   logic [31:0] phase_elapsed;
   logic [31:0] check_elapsed;
   logic [18:0] rev_scaled;
   logic [19:0] rev_duration;
   logic        power_on;
   logic [3:0]  retry_inc;
   logic [7:0]  debounce_inc;
   logic [7:0]  reverse_drive;

   assign phase_elapsed = now_ms - cur.phase_start_time;
   assign check_elapsed = now_ms - cur.last_check_time;
   // base + (base/2) * retries; at most 20 bits
   assign rev_scaled   = {4'b0, cfg.base_reverse_ms[15:1]} * {15'b0, cur.retry_count};
   assign rev_duration = {4'b0, cfg.base_reverse_ms} + {1'b0, rev_scaled};
   assign power_on     = target_power != 8'sd0;
   assign retry_inc    = (cur.retry_count != 4'hF) ? cur.retry_count + 4'd1 : cur.retry_count;
   assign debounce_inc = (cur.debounce_count != 8'hFF) ? cur.debounce_count + 8'd1
                                                       : cur.debounce_count;
   // drive opposite to the request sign
   assign reverse_drive = target_power[7] ? {1'b0, cfg.reverse_power}
                                          : 8'd0 - {1'b0, cfg.reverse_power};

   always_comb begin
      nxt    = cur;
      result = '0;
      unique case (cur.phase)
         msrs_pkg::PHASE_REV: begin
            if (phase_elapsed >= {12'b0, rev_duration}) begin
               nxt.phase            = msrs_pkg::PHASE_PAUSE;
               nxt.phase_start_time = now_ms;
               result.drive_update  = 1'b1;
            end
         end
         msrs_pkg::PHASE_PAUSE: begin
            if (phase_elapsed >= {16'b0, cfg.pause_ms}) begin
               nxt.phase            = msrs_pkg::PHASE_COOL;
               nxt.phase_start_time = now_ms;
               result.drive_update  = 1'b1;
               result.drive_value   = target_power;
            end
         end
         msrs_pkg::PHASE_COOL: begin
            if (phase_elapsed >= {16'b0, cfg.cooldown_ms}) begin
               if (stalled && power_on) begin
                  nxt.retry_count = retry_inc;
                  if (retry_inc >= cfg.max_retries) begin
                     nxt.phase          = msrs_pkg::PHASE_IDLE;
                     nxt.retry_count    = 4'd0;
                     nxt.debounce_count = 8'd0;
                     result.gave_up     = 1'b1;
                  end else begin
                     nxt.phase            = msrs_pkg::PHASE_REV;
                     nxt.phase_start_time = now_ms;
                     result.drive_update  = 1'b1;
                     result.drive_value   = reverse_drive;
                  end
               end else begin
                  nxt.phase          = msrs_pkg::PHASE_IDLE;
                  nxt.retry_count    = 4'd0;
                  nxt.debounce_count = 8'd0;
               end
            end
         end
         default: begin
            // idle: sample at most once per check interval
            if (check_elapsed >= {16'b0, cfg.check_interval_ms}) begin
               nxt.last_check_time = now_ms;
               if (power_on && stalled) begin
                  nxt.debounce_count = debounce_inc;
                  if (debounce_inc >= cfg.debounce_threshold) begin
                     nxt.phase            = msrs_pkg::PHASE_REV;
                     nxt.phase_start_time = now_ms;
                     nxt.retry_count      = 4'd0;
                     nxt.debounce_count   = 8'd0;
                     result.drive_update  = 1'b1;
                     result.drive_value   = reverse_drive;
                  end
               end else begin
                  nxt.debounce_count = 8'd0;
               end
            end
         end
      endcase
      result.phase_now = nxt.phase;
   end

endmodule
